// ===== hdl/bsfs_pkg.sv =====
// shared constants and types of the block stable frame selector
`timescale 1ns / 1ps
`default_nettype none
package bsfs_pkg;

  localparam int unsigned COUNT_W  = 16;
  localparam int unsigned FRAME_W  = 24;
  localparam int unsigned MATCH_W  = 13;
  localparam int unsigned CFG_W    = 16;
  localparam int unsigned CIDX_W   = 2;

  localparam int unsigned MAX_BLOCKS  = 4096;
  localparam int unsigned BIG_LIMIT   = 20;
  localparam int unsigned BIG_DIVISOR = 7;
  localparam int unsigned SMALL_LIMIT = 10;

  // input tdata: point_count, person_count, frame_number
  localparam int unsigned IN_DATA_W  = 56;
  // output tdata: chosen_frame, matched_blocks, zero fill
  localparam int unsigned OUT_DATA_W = 40;
  localparam int unsigned OUT_USER_W = 2;

  // register indexes of the configuration port
  localparam logic [CIDX_W-1:0] REG_GATE_EN   = 2'd0;
  localparam logic [CIDX_W-1:0] REG_THRESHOLD = 2'd1;
  localparam logic [CIDX_W-1:0] REG_TOTAL     = 2'd2;

  typedef struct packed {
    logic               gate_en;
    logic [COUNT_W-1:0] threshold;
  } gate_cfg_t;

endpackage
`default_nettype wire

// ===== hdl/bsfs_compare.sv =====
// stability test of one sample against the previous one of its run
`timescale 1ns / 1ps
`default_nettype none
module bsfs_compare (
  input  wire logic                       have_prev_i,
  input  wire logic [bsfs_pkg::COUNT_W-1:0] cur_points_i,
  input  wire logic [bsfs_pkg::COUNT_W-1:0] prev_points_i,
  input  wire logic [bsfs_pkg::COUNT_W-1:0] cur_persons_i,
  input  wire logic [bsfs_pkg::COUNT_W-1:0] prev_persons_i,
  input  wire bsfs_pkg::gate_cfg_t        cfg_i,
  output logic                            hit_o
);
  import bsfs_pkg::*;

  logic [COUNT_W-1:0] diff;
  logic [COUNT_W+2:0] diff_x7;
  logic               big, stable, gate_ok;

  always_comb begin
    diff    = (cur_points_i > prev_points_i) ? cur_points_i - prev_points_i
                                             : prev_points_i - cur_points_i;
    // diff <= cur/7 is the same test as 7*diff <= cur
    diff_x7 = {diff, 3'b000} - {3'b000, diff};
    big     = cur_points_i > COUNT_W'(BIG_LIMIT);
    stable  = big ? (diff_x7 <= {3'b000, cur_points_i})
                  : (diff < COUNT_W'(SMALL_LIMIT));
    gate_ok = !cfg_i.gate_en ||
              ((cur_persons_i < cfg_i.threshold) && (prev_persons_i < cfg_i.threshold));
    hit_o   = have_prev_i && gate_ok && stable;
  end

endmodule
`default_nettype wire

// ===== hdl/block_stable_frame_selector.sv =====
// top level of the block stable frame selector
// Takes the per-frame samples of one screen block per item, oldest first, and
// on the sample marked tlast gives one result item: the frame number of the
// latest stable sample of the run (or the run's current frame if none was
// stable), a found flag and the running count of matched blocks. On the
// frame's last block (input tuser) the result carries tlast and the junk flag,
// set when fewer than half of total_blocks matched. Rate: one item per clock
// while the result register is free or being taken when a run's last sample
// is due; the result is registered: an input register feeds a single compare
// and update stage whose run state is read and written in the same cycle, and a
// result register decouples the output side. Items that are not the last of a
// run give no result and never wait on the output.
`timescale 1ns / 1ps
`default_nettype none
module block_stable_frame_selector (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // configuration writes
  input  wire logic                              cfg_we_i,
  input  wire logic [bsfs_pkg::CIDX_W-1:0]       cfg_idx_i,
  input  wire logic [bsfs_pkg::CFG_W-1:0]        cfg_data_i,
  // sample stream
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  // point_count [15:0], person_count [31:16], frame_number [55:32]
  input  wire logic [bsfs_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  input  wire logic                              s_axis_tlast,  // last_of_block
  input  wire logic                              s_axis_tuser,  // last_block
  // result stream
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // chosen_frame [23:0], matched_blocks [36:24], zero [39:37]
  output logic [bsfs_pkg::OUT_DATA_W-1:0]        m_axis_tdata,
  output logic                                   m_axis_tlast,  // frame_end
  // block_found [0], frame_is_junk [1]
  output logic [bsfs_pkg::OUT_USER_W-1:0]        m_axis_tuser
);
  import bsfs_pkg::*;

  // configuration registers
  gate_cfg_t          gate_cfg_q;
  logic [MATCH_W-1:0] total_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gate_cfg_q <= '0;
      total_q    <= MATCH_W'(64);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_GATE_EN:   gate_cfg_q.gate_en   <= cfg_data_i[0];
        REG_THRESHOLD: gate_cfg_q.threshold <= cfg_data_i[COUNT_W-1:0];
        REG_TOTAL:     total_q              <= cfg_data_i[MATCH_W-1:0];
        default: ;
      endcase
    end
  end

  // input register
  logic               in_valid_q;
  logic [COUNT_W-1:0] in_points_q, in_persons_q;
  logic [FRAME_W-1:0] in_frame_q;
  logic               in_last_q, in_last_blk_q;

  // run and frame state
  logic [COUNT_W-1:0] prev_points_q, prev_persons_q;
  logic               have_prev_q, found_q;
  logic [FRAME_W-1:0] found_frame_q;
  logic [MATCH_W-1:0] match_q;

  // result register
  logic               out_valid_q;
  logic [FRAME_W-1:0] out_frame_q;
  logic [MATCH_W-1:0] out_match_q;
  logic               out_found_q, out_junk_q, out_end_q;

  logic               out_free, advance, hit, found_now;
  logic [FRAME_W-1:0] frame_sel;
  logic [MATCH_W-1:0] match_next;
  logic               junk;

  // a run's last sample needs a free result slot, other samples never stall
  assign out_free      = !out_valid_q || m_axis_tready;
  assign advance       = in_valid_q && (!in_last_q || out_free);
  assign s_axis_tready = !in_valid_q || advance;

  bsfs_compare u_compare (
    .have_prev_i    (have_prev_q),
    .cur_points_i   (in_points_q),
    .prev_points_i  (prev_points_q),
    .cur_persons_i  (in_persons_q),
    .prev_persons_i (prev_persons_q),
    .cfg_i          (gate_cfg_q),
    .hit_o          (hit)
  );

  always_comb begin
    found_now  = found_q || hit;
    frame_sel  = hit ? in_frame_q : (found_q ? found_frame_q : in_frame_q);
    match_next = match_q;
    if (found_now && (match_q < MATCH_W'(MAX_BLOCKS))) begin
      match_next = match_q + 1'b1;
    end
    // matches*100 < total*50 reduces to 2*matches < total
    junk = in_last_blk_q && ({match_next, 1'b0} < {1'b0, total_q});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_points_q   <= s_axis_tdata[COUNT_W-1:0];
      in_persons_q  <= s_axis_tdata[2*COUNT_W-1:COUNT_W];
      in_frame_q    <= s_axis_tdata[2*COUNT_W+FRAME_W-1:2*COUNT_W];
      in_last_q     <= s_axis_tlast;
      in_last_blk_q <= s_axis_tuser;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_points_q  <= '0;
      prev_persons_q <= '0;
      have_prev_q    <= 1'b0;
      found_q        <= 1'b0;
      found_frame_q  <= '0;
      match_q        <= '0;
    end else if (advance) begin
      prev_points_q  <= in_points_q;
      prev_persons_q <= in_persons_q;
      if (in_last_q) begin
        // run ends: clear run state, and frame count on the frame's last block
        have_prev_q   <= 1'b0;
        found_q       <= 1'b0;
        found_frame_q <= '0;
        match_q       <= in_last_blk_q ? '0 : match_next;
      end else begin
        have_prev_q   <= 1'b1;
        found_q       <= found_now;
        found_frame_q <= frame_sel;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && in_last_q) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_last_q) begin
      out_frame_q <= frame_sel;
      out_match_q <= match_next;
      out_found_q <= found_now;
      out_junk_q  <= junk;
      out_end_q   <= in_last_blk_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OUT_DATA_W - FRAME_W - MATCH_W){1'b0}}, out_match_q, out_frame_q};
  assign m_axis_tlast  = out_end_q;
  assign m_axis_tuser  = {out_junk_q, out_found_q};

  // a junk mark only comes with the frame's last block
  a_junk_with_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (!out_junk_q || out_end_q))
    else $error("junk flag without frame end");

  // a found block has been counted
  a_found_counted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_found_q |-> (out_match_q != '0))
    else $error("found block not counted");

  // match counter stays within its saturation limit
  a_match_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    match_q <= MATCH_W'(MAX_BLOCKS))
    else $error("match counter beyond limit");

  // a run always restarts without a predecessor
  a_run_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && in_last_q |=> !have_prev_q && !found_q)
    else $error("run state not cleared at end of run");

endmodule
`default_nettype wire
